/* rtl/core/assert_macros.svh */
// Concurrent assertion macros used by the top level of the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/ptrpc_pkg.sv */
// Types and constants of the page table range permission check
package ptrpc_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int PAGE_SHIFT    = 13;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FUNC_W        = 2;
  localparam int PROT_W        = 3;
  localparam int FRAME_W       = 10;
  localparam int NFRAMES_W     = 11;
  localparam int ADDR_W        = 32;
  localparam int LEN_W         = 31;
  localparam int STATUS_W      = 3;
  localparam logic [NFRAMES_W-1:0] NUM_FRAMES_RST = NFRAMES_W'(1024);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET = 2'd0,
    FUNC_CLR = 2'd1,
    FUNC_CHK = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK              = 3'd0,
    ST_BADARG          = 3'd1,
    ST_BELOW           = 3'd2,
    ST_ABOVE           = 3'd3,
    ST_INVALID         = 3'd4,
    ST_PROT            = 3'd5,
    ST_ALREADY_VALID   = 3'd6,
    ST_ALREADY_INVALID = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_WALK   = 2'd2
  } state_e;

  typedef struct packed {
    logic    load;
    logic    set_en;
    logic    clr_en;
    logic    walk_start;
    logic    walk_adv;
    logic    emit;
    status_e status;
    logic    fault_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              frame_bad;
    logic              page_valid;
    logic              chk_badarg;
    logic              chk_below;
    logic              chk_above;
    logic              cur_valid;
    logic              prot_match;
    logic              cur_last;
  } dp_stat_t;

endpackage

/* rtl/core/ptrpc_ctrl.sv */
// Controller state machine of the page table range permission check
module ptrpc_ctrl import ptrpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((func_e'(stat_i.func) == FUNC_CHK) && !stat_i.chk_badarg &&
            !stat_i.chk_below && !stat_i.chk_above) begin
          state_d = S_WALK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (!stat_i.cur_valid || !stat_i.prot_match || stat_i.cur_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.status = ST_BADARG;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_DECODE: begin
        case (func_e'(stat_i.func))
          FUNC_SET: begin
            cmd_o.emit = 1'b1;
            if (stat_i.frame_bad) begin
              cmd_o.status = ST_BADARG;
            end else if (stat_i.page_valid) begin
              cmd_o.status = ST_ALREADY_VALID;
            end else begin
              cmd_o.status = ST_OK;
              cmd_o.set_en = 1'b1;
            end
          end
          FUNC_CLR: begin
            cmd_o.emit = 1'b1;
            if (!stat_i.page_valid) begin
              cmd_o.status = ST_ALREADY_INVALID;
            end else begin
              cmd_o.status = ST_OK;
              cmd_o.clr_en = 1'b1;
            end
          end
          FUNC_CHK: begin
            if (stat_i.chk_badarg) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_BADARG;
            end else if (stat_i.chk_below) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_BELOW;
            end else if (stat_i.chk_above) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_ABOVE;
            end else begin
              cmd_o.walk_start = 1'b1;
            end
          end
          default: begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_BADARG;
          end
        endcase
      end
      S_WALK: begin
        if (!stat_i.cur_valid) begin
          cmd_o.emit      = 1'b1;
          cmd_o.status    = ST_INVALID;
          cmd_o.fault_sel = 1'b1;
        end else if (!stat_i.prot_match) begin
          cmd_o.emit      = 1'b1;
          cmd_o.status    = ST_PROT;
          cmd_o.fault_sel = 1'b1;
        end else if (stat_i.cur_last) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_OK;
        end else begin
          cmd_o.walk_adv = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
        cmd_o.status = ST_BADARG;
      end
    endcase
  end

endmodule

/* rtl/core/ptrpc_dp.sv */
// Datapath of the page table range permission check: table, walk counter, result
module ptrpc_dp import ptrpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NFRAMES_W-1:0] cfg_wdata_i,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [IDX_W-1:0]     page_i,
  input  logic [PROT_W-1:0]    prot_i,
  input  logic [FRAME_W-1:0]   frame_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [LEN_W-1:0]     length_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic                 valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [IDX_W-1:0]     fault_page_o
);

  localparam int FIRST_W = ADDR_W - PAGE_SHIFT;
  localparam int END_W   = ADDR_W + 1;
  localparam int LAST_W  = END_W - PAGE_SHIFT;

  logic [NFRAMES_W-1:0]     num_frames_q;
  logic [FUNC_W-1:0]        func_q;
  logic [IDX_W-1:0]         page_q;
  logic [PROT_W-1:0]        prot_q;
  logic [FRAME_W-1:0]       frame_q;
  logic [ADDR_W-1:0]        address_q;
  logic [LEN_W-1:0]         length_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [PROT_W-1:0]        prot_mem [TABLE_ENTRIES];
  logic [PROT_W-1:0]        rd_q;
  logic [IDX_W-1:0]         cur_q, cur_d;
  logic [IDX_W-1:0]         last_q;
  logic                     res_valid_q;
  logic [STATUS_W-1:0]      status_q;
  logic [IDX_W-1:0]         fault_q;

  logic [FIRST_W-1:0] first_pg;
  logic [END_W-1:0]   end_addr;
  logic [LAST_W-1:0]  last_pg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= NUM_FRAMES_RST;
    end else if (cfg_we_i) begin
      num_frames_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= func_i;
      page_q    <= page_i;
      prot_q    <= prot_i;
      frame_q   <= frame_i;
      address_q <= address_i;
      length_q  <= length_i;
    end
  end

  assign first_pg = address_q[ADDR_W-1:PAGE_SHIFT];
  assign end_addr = {1'b0, address_q} + END_W'(length_q) - END_W'(1);
  assign last_pg  = end_addr[END_W-1:PAGE_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.set_en) begin
      valid_q[page_q] <= 1'b1;
    end else if (cmd_i.clr_en) begin
      valid_q[page_q] <= 1'b0;
    end
  end

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.walk_start) begin
      cur_d = first_pg[IDX_W-1:0];
    end else if (cmd_i.walk_adv) begin
      cur_d = cur_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.walk_start) begin
      last_q <= last_pg[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_en) begin
      prot_mem[page_q] <= prot_q;
    end
    rd_q <= prot_mem[cur_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      fault_q  <= cmd_i.fault_sel ? cur_q : '0;
    end
  end

  always_comb begin
    stat_o.func       = func_q;
    stat_o.frame_bad  = ({1'b0, frame_q} >= num_frames_q);
    stat_o.page_valid = valid_q[page_q];
    stat_o.chk_badarg = (address_q == '0) || (length_q == '0);
    stat_o.chk_below  = (first_pg < FIRST_W'(TABLE_ENTRIES));
    stat_o.chk_above  = (last_pg >= LAST_W'(2 * TABLE_ENTRIES));
    stat_o.cur_valid  = valid_q[cur_q];
    stat_o.prot_match = (rd_q == prot_q);
    stat_o.cur_last   = (cur_q == last_q);
  end

  assign valid_o      = res_valid_q;
  assign status_o     = status_q;
  assign fault_page_o = fault_q;

endmodule

/* rtl/core/page_table_range_permission_check.sv */
// Top level of the page table range permission check
// Set and clear are decided in DECODE and their result registered to valid_o;
// a check walks pages in WALK up to and including the first failing page (or
// all pages of the buffer), since the protection table has one read port and
// the walk reads one entry per cycle. Range and argument errors of a check
// return from DECODE. Each result is shown for exactly one cycle with valid_o
// and cannot be held off; busy drops in that cycle, so the next start may
// coincide with it. Valid bits reset cleared at once, so no clearing pass
// follows reset. Write num_frames only while busy is low.
`include "assert_macros.svh"

module page_table_range_permission_check import ptrpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NFRAMES_W-1:0] cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [IDX_W-1:0]     page_i,
  input  logic [PROT_W-1:0]    prot_i,
  input  logic [FRAME_W-1:0]   frame_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [LEN_W-1:0]     length_i,
  output logic                 valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [IDX_W-1:0]     fault_page_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptrpc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ptrpc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .page_i       (page_i),
    .prot_i       (prot_i),
    .frame_i      (frame_i),
    .address_i    (address_i),
    .length_i     (length_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .fault_page_o (fault_page_o)
  );

`ASSERT_RST(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accepted beat did not raise busy")
`ASSERT_RST(a_result_idle, clk_i, rst_ni, valid_o |-> !busy, "result strobe while busy")
`ASSERT_RST(a_result_single, clk_i, rst_ni, valid_o |=> !valid_o, "result strobe held two cycles")
`ASSERT_RST(a_fault_status, clk_i, rst_ni, (valid_o && (fault_page_o != '0)) |-> ((status_o == ST_INVALID) || (status_o == ST_PROT)), "fault page set for a status without fault")
`ASSERT_RST(a_table_stable, clk_i, rst_ni, (cmd.set_en || cmd.clr_en) |-> cmd.emit, "table written without a result")

endmodule

/* test/page_table_range_permission_check_test.sv */
// Testbench for the page table range permission check: predicted status and fault page per command
module page_table_range_permission_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptrpc_pkg::*;

  localparam logic [1:0] BEAT_OP    = 2'd0;
  localparam logic [1:0] BEAT_CFG   = 2'd1;
  localparam logic [1:0] BEAT_DRAIN = 2'd2;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 24;
  localparam int unsigned DIRECTED_OPS  = 25;
  localparam int unsigned RANDOM_OPS    = 475;
  localparam int unsigned PAGE_BYTES    = 1 << PAGE_SHIFT;
  localparam int unsigned REGION_BASE   = TABLE_ENTRIES << PAGE_SHIFT;

  typedef struct packed {
    logic [1:0]           kind;
    logic [FUNC_W-1:0]    func;
    logic [IDX_W-1:0]     page;
    logic [PROT_W-1:0]    prot;
    logic [FRAME_W-1:0]   frame;
    logic [ADDR_W-1:0]    address;
    logic [LEN_W-1:0]     length;
    logic [NFRAMES_W-1:0] frames;
    logic [2:0]           gap;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    fault;
  } outcome_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [NFRAMES_W-1:0] cfg_wdata = '0;
  logic                 start_q   = 1'b0;
  logic                 busy;
  logic [FUNC_W-1:0]    func_q    = '0;
  logic [IDX_W-1:0]     page_q    = '0;
  logic [PROT_W-1:0]    prot_q    = '0;
  logic [FRAME_W-1:0]   frame_q   = '0;
  logic [ADDR_W-1:0]    address_q = '0;
  logic [LEN_W-1:0]     length_q  = '0;
  logic                 valid_o;
  logic [STATUS_W-1:0]  status_o;
  logic [IDX_W-1:0]     fault_page_o;

  cmd_t     cmd_q[$];
  outcome_t outcome_q[$];
  cmd_t     cur_cmd     = '0;
  logic     beat_taken  = 1'b0;
  int unsigned idle_left   = 0;
  int unsigned settle_left = SETTLE_CYCLES;
  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned ops_queued  = 0;
  int unsigned gen_frames  = 32'(NUM_FRAMES_RST);
  logic        no_idle     = 1'b0;

  logic [NFRAMES_W-1:0] frames_limit;
  logic                 tbl_valid [TABLE_ENTRIES];
  logic [PROT_W-1:0]    tbl_prot  [TABLE_ENTRIES];

  page_table_range_permission_check dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .start        (start_q),
    .busy         (busy),
    .func_i       (func_q),
    .page_i       (page_q),
    .prot_i       (prot_q),
    .frame_i      (frame_q),
    .address_i    (address_q),
    .length_i     (length_q),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .fault_page_o (fault_page_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic outcome_t permission_outcome(input cmd_t c);
    outcome_t         res;
    int unsigned      first_pg;
    int unsigned      last_pg;
    int unsigned      pg;
    logic [ADDR_W:0]  last_byte;
    logic [IDX_W-1:0] idx;
    logic             hit;
    res.status = ST_BADARG;
    res.fault  = '0;
    case (c.func)
      FUNC_SET: begin
        if (int'(c.page) >= TABLE_ENTRIES || {1'b0, c.frame} >= frames_limit) begin
          res.status = ST_BADARG;
        end else if (tbl_valid[c.page]) begin
          res.status = ST_ALREADY_VALID;
        end else begin
          tbl_valid[c.page] = 1'b1;
          tbl_prot[c.page]  = c.prot;
          res.status = ST_OK;
        end
      end
      FUNC_CLR: begin
        if (int'(c.page) >= TABLE_ENTRIES) begin
          res.status = ST_BADARG;
        end else if (!tbl_valid[c.page]) begin
          res.status = ST_ALREADY_INVALID;
        end else begin
          tbl_valid[c.page] = 1'b0;
          tbl_prot[c.page]  = '0;
          res.status = ST_OK;
        end
      end
      FUNC_CHK: begin
        if (c.address == '0 || c.length == '0) begin
          res.status = ST_BADARG;
        end else begin
          first_pg  = c.address >> PAGE_SHIFT;
          last_byte = {1'b0, c.address} + {2'b0, c.length} - 1'b1;
          last_pg   = 32'(last_byte >> PAGE_SHIFT);
          if (first_pg < TABLE_ENTRIES) begin
            res.status = ST_BELOW;
          end else if (last_pg >= 2 * TABLE_ENTRIES) begin
            res.status = ST_ABOVE;
          end else begin
            res.status = ST_OK;
            hit = 1'b0;
            for (pg = first_pg; pg <= last_pg && !hit; pg++) begin
              idx = IDX_W'(pg - TABLE_ENTRIES);
              if (!tbl_valid[idx]) begin
                res.status = ST_INVALID;
                res.fault  = idx;
                hit = 1'b1;
              end else if (tbl_prot[idx] != c.prot) begin
                res.status = ST_PROT;
                res.fault  = idx;
                hit = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_op(input logic [FUNC_W-1:0] f, input int unsigned pg, input int unsigned pr,
                        input int unsigned fr, input logic [ADDR_W-1:0] a,
                        input logic [LEN_W-1:0] len);
    cmd_t c;
    c         = '0;
    c.kind    = BEAT_OP;
    c.func    = f;
    c.page    = IDX_W'(pg);
    c.prot    = PROT_W'(pr);
    c.frame   = FRAME_W'(fr);
    c.address = a;
    c.length  = len;
    c.gap     = no_idle ? 3'd0 : 3'($urandom_range(7, 0));
    cmd_q.push_back(c);
    ops_queued++;
  endtask

  task automatic add_cfg(input logic [NFRAMES_W-1:0] v);
    cmd_t c;
    c        = '0;
    c.kind   = BEAT_CFG;
    c.frames = v;
    cmd_q.push_back(c);
    gen_frames = 32'(v);
  endtask

  task automatic add_drain();
    cmd_t c;
    c      = '0;
    c.kind = BEAT_DRAIN;
    cmd_q.push_back(c);
  endtask

  task automatic add_span_check(input int unsigned first_idx, input int unsigned npages,
                                input int unsigned pr);
    int unsigned lo_off;
    int unsigned hi_off;
    int unsigned a;
    int unsigned e;
    lo_off = $urandom_range(PAGE_BYTES - 1, 0);
    hi_off = $urandom_range(PAGE_BYTES - 1, (npages == 1) ? lo_off : 0);
    a = REGION_BASE + first_idx * PAGE_BYTES + lo_off;
    e = REGION_BASE + (first_idx + npages - 1) * PAGE_BYTES + hi_off;
    add_op(FUNC_CHK, $urandom_range(TABLE_ENTRIES - 1, 0), pr, $urandom_range(1023, 0),
           ADDR_W'(a), LEN_W'(e - a + 1));
  endtask

  always @(negedge clk_i) begin : driver_proc
    cmd_t nxt;
    logic go;
    logic we;
    go = start_q && !beat_taken;
    we = 1'b0;
    if (rst_ni && !go) begin
      if (idle_left != 0) begin
        idle_left--;
      end else if (cmd_q.size() != 0) begin
        if (cmd_q[0].kind == BEAT_OP) begin
          cur_cmd   = cmd_q.pop_front();
          idle_left = 32'(cur_cmd.gap);
          go        = 1'b1;
        end else if (outcome_q.size() != 0 || start_q || busy) begin
          settle_left = SETTLE_CYCLES;
        end else if (settle_left != 0) begin
          settle_left--;
        end else begin
          nxt = cmd_q.pop_front();
          if (nxt.kind == BEAT_CFG) begin
            we = 1'b1;
            cfg_wdata <= nxt.frames;
          end
          settle_left = SETTLE_CYCLES;
        end
      end
    end
    start_q   <= go;
    cfg_we    <= we;
    func_q    <= cur_cmd.func;
    page_q    <= cur_cmd.page;
    prot_q    <= cur_cmd.prot;
    frame_q   <= cur_cmd.frame;
    address_q <= cur_cmd.address;
    length_q  <= cur_cmd.length;
  end

  always @(posedge clk_i) begin : monitor_proc
    outcome_t want;
    cycle_cnt++;
    if (!rst_ni) begin
      frames_limit = NUM_FRAMES_RST;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_prot[i]  = '0;
      end
      beat_taken = 1'b0;
    end else begin
      if (valid_o) begin
        if (outcome_q.size() == 0) begin
          if (err_cnt < 10) begin
            $display("unexpected result beat: status %0d fault_page %0d", status_o,
                     fault_page_o);
          end
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (status_o !== want.status || fault_page_o !== want.fault) begin
            if (err_cnt < 10) begin
              $display("mismatch: status exp %0d got %0d, fault_page exp %0d got %0d",
                       want.status, status_o, want.fault, fault_page_o);
            end
            err_cnt++;
          end
        end
      end
      if (cfg_we) begin
        frames_limit = cfg_wdata;
      end
      beat_taken = start_q && !busy;
      if (beat_taken) begin
        outcome_q.push_back(permission_outcome(cur_cmd));
      end
    end
  end

  initial begin : timeout_proc
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus_proc
    int unsigned next_cfg_at;
    int unsigned pr;
    int unsigned w;
    int unsigned base;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned fr;
    int unsigned cap;
    int unsigned k;
    int unsigned j;

    add_op(FUNC_SET, 0, 0, 0, '0, '0);
    add_op(FUNC_SET, TABLE_ENTRIES - 1, 7, 1023, '1, '1);
    add_op(FUNC_SET, 0, 5, 3, $urandom(), LEN_W'($urandom()));
    add_op(FUNC_CLR, 5, 2, 9, $urandom(), LEN_W'($urandom()));
    add_op(FUNC_CHK, 0, 0, 0, '0, LEN_W'(16));
    add_op(FUNC_CHK, 0, 0, 0, REGION_BASE, '0);
    add_op(FUNC_CHK, 0, 0, 0, REGION_BASE - 1, LEN_W'(1));
    add_op(FUNC_CHK, 0, 0, 0, REGION_BASE, LEN_W'(1));
    add_op(FUNC_CHK, 0, 7, 0, REGION_BASE, LEN_W'(1));
    add_op(FUNC_CHK, 0, 0, 0, REGION_BASE, LEN_W'(PAGE_BYTES + 1));
    add_op(FUNC_CHK, 0, 7, 0, 2 * REGION_BASE - 1, LEN_W'(1));
    add_op(FUNC_CHK, 0, 7, 0, 2 * REGION_BASE - 1, LEN_W'(2));
    add_op(FUNC_CHK, 0, 7, 0, '1, '1);
    add_op(FUNC_UNUSED, $urandom_range(127, 0), $urandom_range(7, 0), $urandom_range(1023, 0),
           $urandom(), LEN_W'($urandom()));
    add_op(FUNC_SET, 1, 0, 1023, '0, '0);
    add_op(FUNC_CHK, 0, 0, 0, REGION_BASE, LEN_W'(2 * PAGE_BYTES));
    add_op(FUNC_CLR, 0, 0, 0, '0, '0);
    add_op(FUNC_CLR, 0, 0, 0, '0, '0);
    add_op(FUNC_CHK, 0, 0, 0, REGION_BASE, LEN_W'(1));
    add_cfg(NFRAMES_W'(1));
    add_op(FUNC_SET, 2, 3, 1, '0, '0);
    add_op(FUNC_SET, 2, 3, 0, '0, '0);
    add_cfg('0);
    add_op(FUNC_SET, 3, 2, 0, '0, '0);
    add_cfg('1);
    add_op(FUNC_SET, 3, 2, 1023, '0, '0);
    add_op(FUNC_CHK, 0, 0, 0, REGION_BASE, LEN_W'(REGION_BASE));
    add_op(FUNC_CLR, TABLE_ENTRIES - 1, 0, 0, '0, '0);
    add_cfg(NUM_FRAMES_RST);

    next_cfg_at = ops_queued + $urandom_range(120, 60);
    while (ops_queued < DIRECTED_OPS + RANDOM_OPS) begin
      if (ops_queued >= next_cfg_at) begin
        case ($urandom_range(4, 0))
          0:       add_cfg(NUM_FRAMES_RST);
          1:       add_cfg(NFRAMES_W'($urandom_range(1024, 1)));
          2:       add_cfg('1);
          3:       add_cfg(NFRAMES_W'($urandom_range(16, 1)));
          default: add_cfg('0);
        endcase
        next_cfg_at = ops_queued + $urandom_range(120, 60);
      end else if ($urandom_range(15, 0) == 0) begin
        add_drain();
      end
      no_idle = ($urandom_range(3, 0) == 0);
      pr   = $urandom_range(7, 0);
      w    = ($urandom_range(39, 0) == 0) ? $urandom_range(TABLE_ENTRIES, 6)
                                          : $urandom_range(5, 1);
      base = $urandom_range(TABLE_ENTRIES - w, 0);
      cap  = (gen_frames > 1024) ? 1024 : gen_frames;
      for (k = 0; k < w; k++) begin
        if (cap != 0 && $urandom_range(9, 0) != 0) begin
          fr = $urandom_range(cap - 1, 0);
        end else begin
          fr = $urandom_range(1023, 0);
        end
        add_op(FUNC_SET, base + k, ($urandom_range(9, 0) == 0) ? $urandom_range(7, 0) : pr, fr,
               $urandom(), LEN_W'($urandom()));
      end
      n = $urandom_range(4, 2);
      for (k = 0; k < n; k++) begin
        lo = $urandom_range(w - 1, 0);
        hi = $urandom_range(w - 1, lo);
        add_span_check(base + lo, hi - lo + 1,
                       ($urandom_range(4, 0) == 0) ? $urandom_range(7, 0) : pr);
      end
      n = $urandom_range(3, 0);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(2, 0))
          0: add_op(FUNC_W'($urandom_range(3, 0)), $urandom_range(127, 0), $urandom_range(7, 0),
                    $urandom_range(1023, 0), $urandom(), LEN_W'($urandom()));
          1: add_op(FUNC_CHK, $urandom_range(127, 0), $urandom_range(7, 0),
                    $urandom_range(1023, 0), $urandom(),
                    LEN_W'($urandom() >> $urandom_range(31, 0)));
          default: add_span_check($urandom_range(TABLE_ENTRIES - 1, 0), $urandom_range(3, 1),
                                  $urandom_range(7, 0));
        endcase
      end
      if ($urandom_range(1, 0) == 1) begin
        for (j = 0; j < w; j++) begin
          if ($urandom_range(2, 0) != 0) begin
            add_op(FUNC_CLR, base + j, $urandom_range(7, 0), $urandom_range(1023, 0),
                   $urandom(), LEN_W'($urandom()));
          end
        end
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || outcome_q.size() != 0 || start_q) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (outcome_q.size() != 0) begin
      $display("%0d results never arrived", outcome_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* page_table_range_permission_check.f */
+incdir+rtl/core
rtl/core/ptrpc_pkg.sv
rtl/core/ptrpc_ctrl.sv
rtl/core/ptrpc_dp.sv
rtl/core/page_table_range_permission_check.sv
test/page_table_range_permission_check_test.sv
